// ----- design/aavr_pkg.sv -----
// Package for the axis-angle vector rotation block.
// Holds item and CORDIC data types, the arctangent table and the Q2.30 rounding helper.
// No dependencies.
package aavr_pkg;

	localparam int XW = 34;
	localparam int ZW = 34;
	localparam int PW = 70;
	localparam logic signed [XW-1:0] INV_GAIN = 34'sd652032875;
	localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;

	typedef struct packed {
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic signed [31:0] vz;
		logic signed [31:0] wx;
		logic signed [31:0] wy;
		logic signed [31:0] wz;
		logic               neg;
	} item_t;

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
	} rot_t;

	function automatic logic signed [ZW-1:0] atan_lut(input logic [4:0] i);
		logic signed [ZW-1:0] r;
		case (i)
			5'd0: r = 34'sd536870912;
			5'd1: r = 34'sd316933406;
			5'd2: r = 34'sd167458907;
			5'd3: r = 34'sd85004756;
			5'd4: r = 34'sd42667331;
			5'd5: r = 34'sd21354465;
			5'd6: r = 34'sd10679838;
			5'd7: r = 34'sd5340245;
			5'd8: r = 34'sd2670163;
			5'd9: r = 34'sd1335087;
			5'd10: r = 34'sd667544;
			5'd11: r = 34'sd333772;
			5'd12: r = 34'sd166886;
			5'd13: r = 34'sd83443;
			5'd14: r = 34'sd41722;
			5'd15: r = 34'sd20861;
			5'd16: r = 34'sd10430;
			5'd17: r = 34'sd5215;
			5'd18: r = 34'sd2608;
			5'd19: r = 34'sd1304;
			5'd20: r = 34'sd652;
			5'd21: r = 34'sd326;
			5'd22: r = 34'sd163;
			5'd23: r = 34'sd81;
			5'd24: r = 34'sd41;
			5'd25: r = 34'sd20;
			5'd26: r = 34'sd10;
			5'd27: r = 34'sd5;
			5'd28: r = 34'sd3;
			5'd29: r = 34'sd1;
			5'd30: r = 34'sd1;
			default: r = 34'sd0;
		endcase
		return r;
	endfunction

	// Q2.30 rounding of an exact product, nearest with ties away from zero
	function automatic logic signed [PW-1:0] rnd30(input logic signed [PW-1:0] p);
		logic signed [PW-1:0] m;
		logic signed [PW-1:0] r;
		m = (p < 0) ? -p : p;
		r = (m + (PW'(1) <<< 29)) >>> 30;
		return (p < 0) ? -r : r;
	endfunction

endpackage

// ----- design/aavr_cordic_cell.sv -----
// One rotation-mode CORDIC cell with a fixed shift and arctangent step.
// Carries the item alongside the rotation state. Depends on aavr_pkg.
module aavr_cordic_cell import aavr_pkg::*; #(
	parameter int SHIFT = 0
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  valid_i,
	input  item_t item_i,
	input  rot_t  rot_i,
	output logic  valid_o,
	output item_t item_o,
	output rot_t  rot_o
);

	localparam logic signed [ZW-1:0] ATAN = atan_lut(5'(SHIFT));

	logic valid_q;
	item_t item_q;
	rot_t rot_q;
	logic signed [XW-1:0] dx;
	logic signed [XW-1:0] dy;

	assign dx = rot_i.y >>> SHIFT;
	assign dy = rot_i.x >>> SHIFT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_q <= item_i;
			if (rot_i.z >= 0) begin
				rot_q.x <= rot_i.x - dx;
				rot_q.y <= rot_i.y + dy;
				rot_q.z <= rot_i.z - ATAN;
			end else begin
				rot_q.x <= rot_i.x + dx;
				rot_q.y <= rot_i.y - dy;
				rot_q.z <= rot_i.z + ATAN;
			end
		end
	end

	assign valid_o = valid_q;
	assign item_o = item_q;
	assign rot_o = rot_q;

endmodule

// ----- design/axis_angle_vector_rotation.sv -----
// Axis-angle vector rotation top level: CORDIC cell chain, Rodrigues matrix and product.
// Depends on aavr_pkg and aavr_cordic_cell.
// Takes one item per cycle while in_stall is low and gives one result per item; the pipeline
// is the chain of CORDIC cells followed by eight arithmetic stages and the output register.
// The whole pipeline holds while a result waits under stall.
module axis_angle_vector_rotation import aavr_pkg::*; #(
	parameter int CORDIC_STAGES = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] vec_x,
	input  logic signed [31:0] vec_y,
	input  logic signed [31:0] vec_z,
	input  logic signed [31:0] axis_x,
	input  logic signed [31:0] axis_y,
	input  logic signed [31:0] axis_z,
	input  logic signed [31:0] angle,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z,
	output logic               saturated
);

	localparam int NS = 8;

	logic en;
	logic valid_c [CORDIC_STAGES+1];
	item_t item_c [CORDIC_STAGES+1];
	rot_t rot_c [CORDIC_STAGES+1];
	logic [NS:1] vp_q;
	logic signed [ZW-1:0] z0;
	logic neg0;

	logic signed [XW-1:0] cn, sn, cc, sc;
	logic signed [31:0] c_s1, s_s1, c_s2, c_s3, c_s4, c_s5;
	logic signed [32:0] omc_s1, omc_s2, omc_s3;
	item_t item_s1, item_s2;
	logic signed [31:0] v_s3 [3];
	logic signed [31:0] v_s4 [3];
	logic signed [31:0] v_s5 [3];
	logic signed [31:0] v_s6 [3];
	logic signed [63:0] ww_s2 [6];
	logic signed [63:0] sw_s2 [3];
	logic signed [33:0] ww_s3 [6];
	logic signed [32:0] sw_s3 [3];
	logic signed [32:0] sw_s4 [3];
	logic signed [32:0] sw_s5 [3];
	logic signed [66:0] ww_s4 [6];
	logic signed [34:0] ww_s5 [6];
	logic signed [36:0] m_s6 [9];
	logic signed [68:0] p_s7 [9];
	logic signed [40:0] r_s8 [3];
	logic signed [71:0] rowsum [3];
	logic signed [40:0] rr [3];
	logic [2:0] sat_v;

	assign en = !out_valid || !out_stall;
	assign in_stall = !en;

	always_comb begin
		neg0 = 1'b0;
		z0 = ZW'(angle);
		if (angle > ONE_Q30) begin
			z0 = ZW'(angle) - (ZW'(ONE_Q30) <<< 1);
			neg0 = 1'b1;
		end else if (angle < -ONE_Q30) begin
			z0 = ZW'(angle) + (ZW'(ONE_Q30) <<< 1);
			neg0 = 1'b1;
		end
	end

	assign valid_c[0] = in_valid;
	assign item_c[0] = '{vx: vec_x, vy: vec_y, vz: vec_z, wx: axis_x, wy: axis_y,
		wz: axis_z, neg: neg0};
	assign rot_c[0] = '{x: INV_GAIN, y: '0, z: z0};

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
		aavr_cordic_cell #(.SHIFT(i)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.valid_i(valid_c[i]),
			.item_i (item_c[i]),
			.rot_i  (rot_c[i]),
			.valid_o(valid_c[i+1]),
			.item_o (item_c[i+1]),
			.rot_o  (rot_c[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vp_q <= '0;
			out_valid <= 1'b0;
		end else if (en) begin
			vp_q <= {vp_q[NS-1:1], valid_c[CORDIC_STAGES]};
			out_valid <= vp_q[NS];
		end
	end

	always_comb begin
		cn = item_c[CORDIC_STAGES].neg ? -rot_c[CORDIC_STAGES].x : rot_c[CORDIC_STAGES].x;
		sn = item_c[CORDIC_STAGES].neg ? -rot_c[CORDIC_STAGES].y : rot_c[CORDIC_STAGES].y;
		cc = cn;
		sc = sn;
		if (cn > XW'(ONE_Q30)) cc = XW'(ONE_Q30);
		if (cn < -XW'(ONE_Q30)) cc = -XW'(ONE_Q30);
		if (sn > XW'(ONE_Q30)) sc = XW'(ONE_Q30);
		if (sn < -XW'(ONE_Q30)) sc = -XW'(ONE_Q30);
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			rowsum[k] = 72'(p_s7[3*k]) + 72'(p_s7[3*k+1]) + 72'(p_s7[3*k+2])
				+ (72'sd1 <<< 29);
			rr[k] = 41'(rowsum[k] >>> 30);
			sat_v[k] = (r_s8[k] > 41'sd2147483647) || (r_s8[k] < -41'sd2147483648);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s1 <= 32'(cc);
			s_s1 <= 32'(sc);
			omc_s1 <= 33'(ONE_Q30) - 33'(cc);
			item_s1 <= item_c[CORDIC_STAGES];

			c_s2 <= c_s1;
			omc_s2 <= omc_s1;
			item_s2 <= item_s1;
			ww_s2[0] <= 64'(item_s1.wx) * 64'(item_s1.wx);
			ww_s2[1] <= 64'(item_s1.wy) * 64'(item_s1.wy);
			ww_s2[2] <= 64'(item_s1.wz) * 64'(item_s1.wz);
			ww_s2[3] <= 64'(item_s1.wx) * 64'(item_s1.wy);
			ww_s2[4] <= 64'(item_s1.wx) * 64'(item_s1.wz);
			ww_s2[5] <= 64'(item_s1.wy) * 64'(item_s1.wz);
			sw_s2[0] <= 64'(item_s1.wx) * 64'(s_s1);
			sw_s2[1] <= 64'(item_s1.wy) * 64'(s_s1);
			sw_s2[2] <= 64'(item_s1.wz) * 64'(s_s1);

			c_s3 <= c_s2;
			omc_s3 <= omc_s2;
			v_s3[0] <= item_s2.vx;
			v_s3[1] <= item_s2.vy;
			v_s3[2] <= item_s2.vz;
			for (int k = 0; k < 6; k++) ww_s3[k] <= 34'(rnd30(PW'(ww_s2[k])));
			for (int k = 0; k < 3; k++) sw_s3[k] <= 33'(rnd30(PW'(sw_s2[k])));

			c_s4 <= c_s3;
			v_s4 <= v_s3;
			sw_s4 <= sw_s3;
			for (int k = 0; k < 6; k++) ww_s4[k] <= 67'(ww_s3[k]) * 67'(omc_s3);

			c_s5 <= c_s4;
			v_s5 <= v_s4;
			sw_s5 <= sw_s4;
			for (int k = 0; k < 6; k++) ww_s5[k] <= 35'(rnd30(PW'(ww_s4[k])));

			v_s6 <= v_s5;
			m_s6[0] <= 37'(c_s5) + 37'(ww_s5[0]);
			m_s6[1] <= 37'(ww_s5[3]) - 37'(sw_s5[2]);
			m_s6[2] <= 37'(ww_s5[4]) + 37'(sw_s5[1]);
			m_s6[3] <= 37'(ww_s5[3]) + 37'(sw_s5[2]);
			m_s6[4] <= 37'(c_s5) + 37'(ww_s5[1]);
			m_s6[5] <= 37'(ww_s5[5]) - 37'(sw_s5[0]);
			m_s6[6] <= 37'(ww_s5[4]) - 37'(sw_s5[1]);
			m_s6[7] <= 37'(ww_s5[5]) + 37'(sw_s5[0]);
			m_s6[8] <= 37'(c_s5) + 37'(ww_s5[2]);

			for (int k = 0; k < 9; k++) p_s7[k] <= 69'(m_s6[k]) * 69'(v_s6[k % 3]);

			for (int k = 0; k < 3; k++) r_s8[k] <= rr[k];

			out_x <= sat_v[0] ? (r_s8[0][40] ? 32'sh80000000 : 32'sh7fffffff) : 32'(r_s8[0]);
			out_y <= sat_v[1] ? (r_s8[1][40] ? 32'sh80000000 : 32'sh7fffffff) : 32'(r_s8[1]);
			out_z <= sat_v[2] ? (r_s8[2][40] ? 32'sh80000000 : 32'sh7fffffff) : 32'(r_s8[2]);
			saturated <= |sat_v;
		end
	end

endmodule
